FILE: hdl/pnz_pkg.sv
// Shared types, constants and the gradient dot function for the 2D noise block.
`timescale 1ns / 1ps

package pnz_pkg;

   localparam int PERM_SIZE = 256;
   localparam int PERM_W    = 8;
   localparam int GRAD_W    = 3;
   localparam int COORD_W   = 32;
   localparam int SCALE_W   = 16;
   localparam int PROD_W    = COORD_W + SCALE_W + 1;
   localparam int FRAC_W    = 16;
   localparam int OFS_W     = FRAC_W + 2;
   localparam int DOT_W     = OFS_W + 1;
   localparam int FADE_W    = 21;
   localparam int OUT_W     = 16;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
   localparam logic signed [OFS_W-1:0] ONE_Q16 = 18'sd65536;

   localparam logic [GRAD_W-1:0] GRAD_PP = 3'd0;
   localparam logic [GRAD_W-1:0] GRAD_NP = 3'd1;
   localparam logic [GRAD_W-1:0] GRAD_PN = 3'd2;
   localparam logic [GRAD_W-1:0] GRAD_NN = 3'd3;
   localparam logic [GRAD_W-1:0] GRAD_PX = 3'd4;
   localparam logic [GRAD_W-1:0] GRAD_NX = 3'd5;
   localparam logic [GRAD_W-1:0] GRAD_PY = 3'd6;
   localparam logic [GRAD_W-1:0] GRAD_NY = 3'd7;

   typedef logic [PERM_W-1:0]        perm_type;
   typedef logic [GRAD_W-1:0]        grad_type;
   typedef logic [FRAC_W-1:0]        frac_type;
   typedef logic signed [OFS_W-1:0]  ofs_type;
   typedef logic signed [DOT_W-1:0]  dot_type;
   typedef logic signed [FADE_W-1:0] fade_type;

   typedef struct packed {
      logic     en;
      perm_type idx;
      perm_type val;
   } perm_wr_type;

   function automatic dot_type corner_dot(grad_type g, ofs_type ox, ofs_type oy);
      dot_type x;
      dot_type y;
      dot_type r;
      x = DOT_W'(ox);
      y = DOT_W'(oy);
      case (g)
         GRAD_PP: r = x + y;
         GRAD_NP: r = y - x;
         GRAD_PN: r = x - y;
         GRAD_NN: r = -x - y;
         GRAD_PX: r = x;
         GRAD_NX: r = -x;
         GRAD_PY: r = y;
         GRAD_NY: r = -y;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/pnz_perm_mem.sv
// Permutation store: paired banks giving an entry and its successor in one read.
`timescale 1ns / 1ps

module pnz_perm_mem (
   input  logic                clock,
   input  logic                rd_en,
   input  pnz_pkg::perm_wr_type wr,
   input  pnz_pkg::perm_type   hash_addr,
   input  pnz_pkg::perm_type   grad_addr0,
   input  pnz_pkg::perm_type   grad_addr1,
   output pnz_pkg::perm_type   hash_lo,
   output pnz_pkg::perm_type   hash_hi,
   output pnz_pkg::grad_type   grad_s,
   output pnz_pkg::grad_type   grad_t,
   output pnz_pkg::grad_type   grad_u,
   output pnz_pkg::grad_type   grad_v
);
   import pnz_pkg::*;

   perm_type hash_lo_mem [PERM_SIZE];
   perm_type hash_hi_mem [PERM_SIZE];
   grad_type grad_lo_mem [PERM_SIZE];
   grad_type grad_hi_mem [PERM_SIZE];

   perm_type hash_lo_ff, hash_hi_ff;
   grad_type grad_s_ff, grad_t_ff, grad_u_ff, grad_v_ff;
   perm_type prev_idx;

   assign prev_idx = wr.idx - 8'd1;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         hash_lo_mem[wr.idx]   <= wr.val;
         hash_hi_mem[prev_idx] <= wr.val;
         grad_lo_mem[wr.idx]   <= wr.val[GRAD_W-1:0];
         grad_hi_mem[prev_idx] <= wr.val[GRAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         hash_lo_ff <= hash_lo_mem[hash_addr];
         hash_hi_ff <= hash_hi_mem[hash_addr];
         grad_s_ff  <= grad_lo_mem[grad_addr0];
         grad_t_ff  <= grad_hi_mem[grad_addr0];
         grad_u_ff  <= grad_lo_mem[grad_addr1];
         grad_v_ff  <= grad_hi_mem[grad_addr1];
      end
   end

   assign hash_lo = hash_lo_ff;
   assign hash_hi = hash_hi_ff;
   assign grad_s  = grad_s_ff;
   assign grad_t  = grad_t_ff;
   assign grad_u  = grad_u_ff;
   assign grad_v  = grad_v_ff;

endmodule

FILE: hdl/pnz_fade.sv
// Four-stage pipelined quintic fade curve 6t^5-15t^4+10t^3 in Q16.
`timescale 1ns / 1ps

module pnz_fade (
   input  logic              clock,
   input  logic              en,
   input  pnz_pkg::frac_type t_in,
   output pnz_pkg::fade_type fade
);
   import pnz_pkg::*;

   localparam int MUL_W = FRAC_W + 1 + FADE_W;
   localparam logic signed [FADE_W-1:0] SIX     = 21'sd6;
   localparam logic signed [FADE_W-1:0] FIFTEEN = 21'sd983040;
   localparam logic signed [FADE_W-1:0] TEN     = 21'sd655360;

   logic signed [FRAC_W:0]  t0, t1, t2, t3;
   logic signed [FADE_W-1:0] a_in, b_in, c_in, d_in;
   frac_type t1_ff, t2_ff, t3_ff;
   logic signed [MUL_W-1:0] ma_ff, mb_ff, mc_ff, md_ff;

   assign t0   = $signed({1'b0, t_in});
   assign t1   = $signed({1'b0, t1_ff});
   assign t2   = $signed({1'b0, t2_ff});
   assign t3   = $signed({1'b0, t3_ff});
   assign a_in = FADE_W'(t0) * SIX - FIFTEEN;
   assign b_in = FADE_W'(ma_ff >>> FRAC_W) + TEN;
   assign c_in = FADE_W'(mb_ff >>> FRAC_W);
   assign d_in = FADE_W'(mc_ff >>> FRAC_W);

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff <= t0 * a_in;
         t1_ff <= t_in;
         mb_ff <= t1 * b_in;
         t2_ff <= t1_ff;
         mc_ff <= t2 * c_in;
         t3_ff <= t2_ff;
         md_ff <= t3 * d_in;
      end
   end

   assign fade = FADE_W'(md_ff >>> FRAC_W);

endmodule

FILE: hdl/perlin_noise_2d.sv
// Top level of the 2D gradient noise evaluator with its pipeline and output skid.
`timescale 1ns / 1ps

// The block takes one word per cycle, evaluate or load alike, and returns one noise
// word per evaluate, saturated to signed Q2.14. Each evaluate makes six permutation
// lookups; the store is kept as paired banks so that the hash pair and the four
// corner gradients come from two registered reads in successive stages. A load
// writes its entry in step with those reads, so every word sees exactly the loads
// taken before it. The entries must be loaded before use. Input is stalled only
// while a result sits in the skid stage behind a stalled output.
module perlin_noise_2d #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic signed [pnz_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [pnz_pkg::COORD_W-1:0] req_y_coord,
   input  pnz_pkg::perm_type               req_perm_index,
   input  pnz_pkg::perm_type               req_perm_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [pnz_pkg::OUT_W-1:0] rsp_noise_value,
   input  logic                            csr_write_enable,
   input  logic [pnz_pkg::SCALE_W-1:0]     csr_write_data
);
   import pnz_pkg::*;

   localparam int CELL_SHIFT = FRAC_BITS + 8;
   localparam int DIF_W = DOT_W + 1;
   localparam int LM_W  = FADE_W + DIF_W;
   localparam int L_W   = DOT_W + 2;
   localparam int LD_W  = L_W + 1;
   localparam int FM_W  = FADE_W + LD_W;
   localparam int R_W   = L_W + 2;
   localparam logic signed [R_W-1:0] OUT_MAX = 23'sd32767;
   localparam logic signed [R_W-1:0] OUT_MIN = -23'sd32768;

   localparam int FUNC_EVAL = 0;
   localparam int FUNC_LOAD = 1;

   logic advance, req_accept;
   logic [SCALE_W-1:0] scale_ff;

   logic ev1_ff, ld1_ff, ev2_ff, ld2_ff, ev3_ff, ev4_ff, ev5_ff;
   logic ev6_ff, ev7_ff, ev8_ff, ev9_ff;

   logic signed [COORD_W-1:0] x1_ff, y1_ff;
   perm_type idx1_ff, val1_ff, idx2_ff, val2_ff;
   logic signed [PROD_W-1:0] px_in, py_in;
   perm_type cx2_ff, cy2_ff, cx3_ff;
   frac_type fx2_ff, fy2_ff, fx3_ff, fy3_ff, fx4_ff, fy4_ff;

   perm_wr_type wr;
   perm_type hash_lo, hash_hi;
   grad_type grad_s, grad_t, grad_u, grad_v;
   perm_type grad_addr0, grad_addr1;

   ofs_type ox0, ox1, oy0, oy1;
   dot_type s5_ff, t5_ff, u5_ff, v5_ff, s6_ff, t6_ff, u6_ff, v6_ff, s7_ff, u7_ff;
   fade_type fade_x, fade_y, fy7_ff, fy8_ff;
   logic signed [DIF_W-1:0] d1_in, d2_in;
   logic signed [LM_W-1:0] m1_ff, m2_ff;
   logic signed [L_W-1:0] l1_in, l2_in, l1_8_ff, l2_8_ff, l1_9_ff;
   logic signed [LD_W-1:0] dl_in;
   logic signed [FM_W-1:0] ml_ff;
   logic signed [R_W-1:0] r_full, r_q;
   logic signed [OUT_W-1:0] noise_in, rsp_noise_ff, skid_noise_ff;
   logic rsp_valid_ff, skid_valid_ff;

   assign advance    = !skid_valid_ff;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_write_enable) begin
         scale_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev1_ff <= 1'b0;
         ld1_ff <= 1'b0;
         ev2_ff <= 1'b0;
         ld2_ff <= 1'b0;
         ev3_ff <= 1'b0;
         ev4_ff <= 1'b0;
         ev5_ff <= 1'b0;
         ev6_ff <= 1'b0;
         ev7_ff <= 1'b0;
         ev8_ff <= 1'b0;
         ev9_ff <= 1'b0;
      end else if (advance) begin
         ev1_ff <= req_accept && (req_func == 1'(FUNC_EVAL));
         ld1_ff <= req_accept && (req_func == 1'(FUNC_LOAD));
         ev2_ff <= ev1_ff;
         ld2_ff <= ld1_ff;
         ev3_ff <= ev2_ff;
         ev4_ff <= ev3_ff;
         ev5_ff <= ev4_ff;
         ev6_ff <= ev5_ff;
         ev7_ff <= ev6_ff;
         ev8_ff <= ev7_ff;
         ev9_ff <= ev8_ff;
      end
   end

   assign px_in = $signed(x1_ff) * $signed({1'b0, scale_ff});
   assign py_in = $signed(y1_ff) * $signed({1'b0, scale_ff});

   assign ox0 = $signed({2'b00, fx4_ff});
   assign oy0 = $signed({2'b00, fy4_ff});
   assign ox1 = ox0 - ONE_Q16;
   assign oy1 = oy0 - ONE_Q16;

   assign d1_in = DIF_W'(t6_ff) - DIF_W'(s6_ff);
   assign d2_in = DIF_W'(v6_ff) - DIF_W'(u6_ff);
   assign l1_in = L_W'(s7_ff + (m1_ff >>> FRAC_W));
   assign l2_in = L_W'(u7_ff + (m2_ff >>> FRAC_W));
   assign dl_in = LD_W'(l2_8_ff) - LD_W'(l1_8_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff   <= req_x_coord;
         y1_ff   <= req_y_coord;
         idx1_ff <= req_perm_index;
         val1_ff <= req_perm_value;
         idx2_ff <= idx1_ff;
         val2_ff <= val1_ff;
         cx2_ff  <= px_in[CELL_SHIFT +: PERM_W];
         cy2_ff  <= py_in[CELL_SHIFT +: PERM_W];
         fx2_ff  <= px_in[CELL_SHIFT-1 -: FRAC_W];
         fy2_ff  <= py_in[CELL_SHIFT-1 -: FRAC_W];
         cx3_ff  <= cx2_ff;
         fx3_ff  <= fx2_ff;
         fy3_ff  <= fy2_ff;
         fx4_ff  <= fx3_ff;
         fy4_ff  <= fy3_ff;
         s5_ff   <= corner_dot(grad_s, ox0, oy0);
         t5_ff   <= corner_dot(grad_t, ox1, oy0);
         u5_ff   <= corner_dot(grad_u, ox0, oy1);
         v5_ff   <= corner_dot(grad_v, ox1, oy1);
         s6_ff   <= s5_ff;
         t6_ff   <= t5_ff;
         u6_ff   <= u5_ff;
         v6_ff   <= v5_ff;
         m1_ff   <= fade_x * d1_in;
         m2_ff   <= fade_x * d2_in;
         s7_ff   <= s6_ff;
         u7_ff   <= u6_ff;
         fy7_ff  <= fade_y;
         l1_8_ff <= l1_in;
         l2_8_ff <= l2_in;
         fy8_ff  <= fy7_ff;
         ml_ff   <= fy8_ff * dl_in;
         l1_9_ff <= l1_8_ff;
      end
   end

   assign wr.en  = advance && ld2_ff;
   assign wr.idx = idx2_ff;
   assign wr.val = val2_ff;
   assign grad_addr0 = cx3_ff + hash_lo;
   assign grad_addr1 = cx3_ff + hash_hi;

   pnz_perm_mem u_perm_mem (
      .clock      (clock),
      .rd_en      (advance),
      .wr         (wr),
      .hash_addr  (cy2_ff),
      .grad_addr0 (grad_addr0),
      .grad_addr1 (grad_addr1),
      .hash_lo    (hash_lo),
      .hash_hi    (hash_hi),
      .grad_s     (grad_s),
      .grad_t     (grad_t),
      .grad_u     (grad_u),
      .grad_v     (grad_v)
   );

   pnz_fade u_fade_x (
      .clock (clock),
      .en    (advance),
      .t_in  (fx2_ff),
      .fade  (fade_x)
   );

   pnz_fade u_fade_y (
      .clock (clock),
      .en    (advance),
      .t_in  (fy2_ff),
      .fade  (fade_y)
   );

   assign r_full = R_W'(l1_9_ff + (ml_ff >>> FRAC_W));
   assign r_q    = r_full >>> 2;

   always_comb begin
      if (r_q > OUT_MAX) begin
         noise_in = OUT_MAX[OUT_W-1:0];
      end else if (r_q < OUT_MIN) begin
         noise_in = OUT_MIN[OUT_W-1:0];
      end else begin
         noise_in = r_q[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && rsp_stall) begin
         if (advance && ev9_ff) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ev9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && rsp_stall) begin
         if (advance && ev9_ff) begin
            skid_noise_ff <= noise_in;
         end
      end else if (skid_valid_ff) begin
         rsp_noise_ff <= skid_noise_ff;
      end else begin
         rsp_noise_ff <= noise_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

   a_skid_needs_output : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held without a pending output word");

   a_one_kind : assert property (@(posedge clock) disable iff (reset)
      $onehot0({ld1_ff, ev1_ff}))
      else $error("first stage holds both a load and an evaluate");

   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall && ev9_ff))
      else $error("skid filled without a stalled output and a finished word");

   a_skid_drain : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> rsp_valid_ff && !skid_valid_ff)
      else $error("skid word not moved to the output");

endmodule
